/* design/krbcg_pkg.sv */
// shared types, constants and codes for the key release blink code generator
package krbcg_pkg;

  localparam int FIFO_DEPTH = 16;
  localparam int PTR_W      = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);
  localparam int KEYS       = 4;
  localparam int CODE_W     = 2;
  localparam int TIME_W     = 32;
  localparam int QUEUED_W   = 5;
  localparam int CFG_IDX_W  = 2;

  localparam logic [TIME_W-1:0] HIGH_TIME_RST  = TIME_W'(1280);
  localparam logic [TIME_W-1:0] LOW_TIME_RST   = TIME_W'(1920);
  localparam logic [TIME_W-1:0] PAUSE_TIME_RST = TIME_W'(32000);

  localparam logic [CFG_IDX_W-1:0] CFG_HIGH_TIME  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOW_TIME   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PAUSE_TIME = 2'd2;

  typedef enum logic [1:0] {
    PH_READY = 2'd0,
    PH_HIGH  = 2'd1,
    PH_LOW   = 2'd2,
    PH_PAUSE = 2'd3
  } phase_t;

  typedef struct packed {
    logic [KEYS-1:0]   key_pins;
    logic [TIME_W-1:0] now;
  } in_word_t;

  typedef struct packed {
    logic                led_on;
    logic [QUEUED_W-1:0] queued;
    logic                dropped;
  } out_word_t;

  // one classified round between front and back
  typedef struct packed {
    logic [KEYS-1:0]   released;
    logic [TIME_W-1:0] now;
  } round_t;

endpackage

/* design/krbcg_front.sv */
// front end: edge detection of key releases per round
module krbcg_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  krbcg_pkg::in_word_t in_data,
  output logic                q_valid,
  input  logic                q_ready,
  output krbcg_pkg::round_t   q_data
);
  import krbcg_pkg::*;

  logic [KEYS-1:0] prev_pressed_r;
  logic [KEYS-1:0] prev_pressed_nxt;
  logic            take;

  assign in_ready = q_ready;
  assign q_valid  = in_valid;
  assign take     = in_valid && q_ready;

  // pins are active low: a release is pressed last round and high now
  assign q_data.released = prev_pressed_r & in_data.key_pins;
  assign q_data.now      = in_data.now;

  always_comb begin
    prev_pressed_nxt = prev_pressed_r;
    if (take) begin
      prev_pressed_nxt = ~in_data.key_pins;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_pressed_r <= '0;
    end else begin
      prev_pressed_r <= prev_pressed_nxt;
    end
  end

endmodule

/* design/krbcg_queue.sv */
// two-entry round queue between front and back
module krbcg_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_valid,
  output logic              wr_ready,
  input  krbcg_pkg::round_t wr_data,
  output logic              rd_valid,
  input  logic              rd_ready,
  output krbcg_pkg::round_t rd_data
);
  import krbcg_pkg::*;

  round_t     entry_r [2];
  logic       wr_ptr_r;
  logic       wr_ptr_nxt;
  logic       rd_ptr_r;
  logic       rd_ptr_nxt;
  logic [1:0] count_r;
  logic [1:0] count_nxt;
  logic       push;
  logic       pop;

  assign wr_ready = (count_r != 2'd2);
  assign rd_valid = (count_r != 2'd0);
  assign rd_data  = entry_r[rd_ptr_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

/* design/krbcg_back.sv */
// back end: key fifo, led sequencer, timing registers and result register
module krbcg_back (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  input  logic [krbcg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [krbcg_pkg::TIME_W-1:0]   cfg_data,
  input  logic                           q_valid,
  output logic                           q_ready,
  input  krbcg_pkg::round_t              q_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output krbcg_pkg::out_word_t           out_data
);
  import krbcg_pkg::*;

  logic [TIME_W-1:0] high_time_r;
  logic [TIME_W-1:0] low_time_r;
  logic [TIME_W-1:0] pause_time_r;

  logic [CODE_W-1:0] store_r   [FIFO_DEPTH];
  logic [CODE_W-1:0] store_nxt [FIFO_DEPTH];
  logic [PTR_W-1:0]  head_r;
  logic [PTR_W-1:0]  head_nxt;
  logic [CNT_W-1:0]  fill_r;
  logic [CNT_W-1:0]  fill_nxt;

  phase_t            phase_r;
  phase_t            phase_nxt;
  logic [CODE_W-1:0] pulses_r;
  logic [CODE_W-1:0] pulses_nxt;
  logic [TIME_W-1:0] start_r;
  logic [TIME_W-1:0] start_nxt;
  logic              led_r;
  logic              led_nxt;

  logic              out_valid_r;
  logic              out_valid_nxt;
  out_word_t         out_word_r;

  logic              take;
  logic [CNT_W-1:0]  cnt;
  logic              drop;
  logic              have_first;
  logic [CODE_W-1:0] first_code;
  logic [TIME_W-1:0] elapsed;

  function automatic logic [PTR_W-1:0] wrap_add(logic [PTR_W-1:0] base,
                                                logic [CNT_W-1:0] off);
    logic [CNT_W:0] sum;
    sum = (CNT_W+1)'(base) + (CNT_W+1)'(off);
    if (sum >= (CNT_W+1)'(FIFO_DEPTH)) begin
      sum = sum - (CNT_W+1)'(FIFO_DEPTH);
    end
    return PTR_W'(sum);
  endfunction

  assign take      = q_valid && (!out_valid_r || out_ready);
  assign q_ready   = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_word_r;

  // pushes in key order, then at most one sequencer step
  always_comb begin
    cnt        = fill_r;
    drop       = 1'b0;
    have_first = 1'b0;
    first_code = '0;
    store_nxt  = store_r;
    for (int k = 0; k < KEYS; k++) begin
      if (q_data.released[KEYS-1-k]) begin
        if (cnt < CNT_W'(FIFO_DEPTH)) begin
          store_nxt[wrap_add(head_r, cnt)] = CODE_W'(k);
          if (!have_first) begin
            have_first = 1'b1;
            first_code = CODE_W'(k);
          end
          cnt = cnt + CNT_W'(1);
        end else begin
          drop = 1'b1;
        end
      end
    end
  end

  assign elapsed = q_data.now - start_r;

  always_comb begin
    phase_nxt  = phase_r;
    pulses_nxt = pulses_r;
    start_nxt  = start_r;
    led_nxt    = led_r;
    head_nxt   = head_r;
    fill_nxt   = cnt;
    unique case (phase_r)
      PH_HIGH: begin
        if (elapsed >= high_time_r) begin
          phase_nxt = PH_LOW;
          led_nxt   = 1'b0;
          start_nxt = q_data.now;
        end
      end
      PH_LOW: begin
        if (elapsed >= low_time_r) begin
          if (pulses_r != '0) begin
            pulses_nxt = pulses_r - CODE_W'(1);
            phase_nxt  = PH_HIGH;
            led_nxt    = 1'b1;
          end else begin
            phase_nxt = PH_PAUSE;
          end
          start_nxt = q_data.now;
        end
      end
      PH_PAUSE: begin
        if (elapsed >= pause_time_r) begin
          phase_nxt = PH_READY;
        end
      end
      PH_READY: begin
        if (cnt != '0) begin
          // an empty fifo hands over the word pushed this round
          pulses_nxt = (fill_r == '0) ? first_code : store_r[head_r];
          head_nxt   = wrap_add(head_r, CNT_W'(1));
          fill_nxt   = cnt - CNT_W'(1);
          phase_nxt  = PH_HIGH;
          led_nxt    = 1'b1;
          start_nxt  = q_data.now;
        end
      end
      default: begin
        phase_nxt = PH_READY;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (take) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_READY;
    end else if (take) begin
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pulses_r    <= '0;
      start_r     <= '0;
      led_r       <= 1'b0;
      head_r      <= '0;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (take) begin
        pulses_r <= pulses_nxt;
        start_r  <= start_nxt;
        led_r    <= led_nxt;
        head_r   <= head_nxt;
        fill_r   <= fill_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      store_r            <= store_nxt;
      out_word_r.led_on  <= led_nxt;
      out_word_r.queued  <= QUEUED_W'(fill_nxt);
      out_word_r.dropped <= drop;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      high_time_r  <= HIGH_TIME_RST;
      low_time_r   <= LOW_TIME_RST;
      pause_time_r <= PAUSE_TIME_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_HIGH_TIME:  high_time_r  <= cfg_data;
        CFG_LOW_TIME:   low_time_r   <= cfg_data;
        CFG_PAUSE_TIME: pause_time_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

endmodule

/* design/key_release_blink_code_generator.sv */
// Key release blink code generator: top level. Each input word is one round
// of four active-low key pins plus the free-running timer; every round gives
// exactly one result word. A new round is taken every clock while results
// are taken: the front part detects releases and hands the round through a
// two-entry queue to the back part, whose 16-entry key fifo and led sequencer
// finish the round, one wrapping 32-bit compare of elapsed time per round.
// A round is registered in the queue and then in the back part's result
// register before its result can be taken. A waiting result holds in an
// output register; meanwhile up to two more rounds fill the queue, and
// then the input stalls. Timing registers (0 high time, 1 low time, 2 pause
// time) are always ready and apply to every round the back part handles after
// the write, so write them only while no round is in flight; other indexes
// are ignored.
module key_release_blink_code_generator (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  krbcg_pkg::in_word_t             in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output krbcg_pkg::out_word_t            out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [krbcg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [krbcg_pkg::TIME_W-1:0]    cfg_data
);
  import krbcg_pkg::*;

  logic   f_valid;
  logic   f_ready;
  round_t f_data;
  logic   b_valid;
  logic   b_ready;
  round_t b_data;

  assign cfg_ready = 1'b1;

  krbcg_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_valid  (f_valid),
    .q_ready  (f_ready),
    .q_data   (f_data)
  );

  krbcg_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .wr_data  (f_data),
    .rd_valid (b_valid),
    .rd_ready (b_ready),
    .rd_data  (b_data)
  );

  krbcg_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_valid   (b_valid),
    .q_ready   (b_ready),
    .q_data    (b_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

/* tb/sv/tb_key_release_blink_code_generator.sv */
// self-checking testbench for the key release blink code generator
module tb_key_release_blink_code_generator;
  import krbcg_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 400;
  localparam int PHASES      = 8;
  localparam int PHASE_WORDS = 190;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  typedef struct packed {
    in_word_t  stim;
    logic      pinned;
    out_word_t want;
  } drill_row_t;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  in_word_t             in_data;
  logic                 out_valid;
  logic                 out_ready;
  out_word_t            out_data;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [TIME_W-1:0]    cfg_data;

  // hand-typed result for the word on offer, used instead of the predictor
  logic      pinned_ok;
  out_word_t pinned_word;

  bit hold_off_req;
  bit no_gaps;
  int mismatches;
  int cycles;

  out_word_t led_status_due[$];
  drill_row_t drill[$];

  // predictor state and its copy of the timing registers
  logic [TIME_W-1:0] t_high, t_low, t_pause;
  logic [KEYS-1:0]   pressed_last;
  logic [CODE_W-1:0] key_fifo[FIFO_DEPTH];
  int                fifo_head;
  int                fifo_fill;
  phase_t            seq_phase;
  logic [CODE_W-1:0] blinks_left;
  logic [TIME_W-1:0] phase_t0;
  logic              led_lit;

  key_release_blink_code_generator i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic out_word_t blink_round(input in_word_t w);
    logic [KEYS-1:0]   down;
    logic [KEYS-1:0]   up;
    logic [TIME_W-1:0] span;
    logic              lost;
    out_word_t         r;
    down = ~w.key_pins;
    up   = pressed_last & ~down;
    lost = 1'b0;
    // key 1 sits in bit 3 and is queued first
    for (int k = 0; k < KEYS; k++) begin
      if (up[KEYS-1-k]) begin
        if (fifo_fill >= FIFO_DEPTH) begin
          lost = 1'b1;
        end else begin
          key_fifo[(fifo_head + fifo_fill) % FIFO_DEPTH] = CODE_W'(k);
          fifo_fill++;
        end
      end
    end
    pressed_last = down;
    span = w.now - phase_t0;
    case (seq_phase)
      PH_HIGH: begin
        if (span >= t_high) begin
          seq_phase = PH_LOW;
          led_lit   = 1'b0;
          phase_t0  = w.now;
        end
      end
      PH_LOW: begin
        if (span >= t_low) begin
          if (blinks_left != '0) begin
            blinks_left = blinks_left - 1'b1;
            seq_phase   = PH_HIGH;
            led_lit     = 1'b1;
          end else begin
            seq_phase = PH_PAUSE;
          end
          phase_t0 = w.now;
        end
      end
      PH_PAUSE: begin
        // phase_t0 is left alone when the pause ends
        if (span >= t_pause) seq_phase = PH_READY;
      end
      default: begin
        if (fifo_fill != 0) begin
          blinks_left = key_fifo[fifo_head];
          fifo_head   = (fifo_head + 1) % FIFO_DEPTH;
          fifo_fill--;
          seq_phase   = PH_HIGH;
          led_lit     = 1'b1;
          phase_t0    = w.now;
        end
      end
    endcase
    r.led_on  = led_lit;
    r.queued  = QUEUED_W'(fifo_fill);
    r.dropped = lost;
    return r;
  endfunction

  task automatic report_bad(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("mismatch: %s", msg);
  endtask

  // scoreboard: results are checked before the word accepted on the same edge is predicted
  always @(posedge clk) begin
    out_word_t want;
    out_word_t got;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (led_status_due.size() == 0) begin
          report_bad("result word with nothing pending");
        end else begin
          want = led_status_due.pop_front();
          if (out_data.led_on !== want.led_on)
            report_bad($sformatf("led_on exp %0d got %0d", want.led_on, out_data.led_on));
          if (out_data.queued !== want.queued)
            report_bad($sformatf("queued exp %0d got %0d", want.queued, out_data.queued));
          if (out_data.dropped !== want.dropped)
            report_bad($sformatf("dropped exp %0d got %0d", want.dropped, out_data.dropped));
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_HIGH_TIME:  t_high  = cfg_data;
          CFG_LOW_TIME:   t_low   = cfg_data;
          CFG_PAUSE_TIME: t_pause = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        got = blink_round(in_data);
        led_status_due.push_back(pinned_ok ? pinned_word : got);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // result side: random back-pressure plus one long hold-off on request
  initial begin
    out_ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (!no_gaps && $urandom_range(0, 99) < 18) begin
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  function automatic void add_row(input logic [KEYS-1:0] pins, input logic [TIME_W-1:0] stamp,
                                  input logic pin, input logic led, input int q,
                                  input logic drop);
    drill_row_t r;
    r.stim.key_pins = pins;
    r.stim.now      = stamp;
    r.pinned        = pin;
    r.want.led_on   = led;
    r.want.queued   = QUEUED_W'(q);
    r.want.dropped  = drop;
    drill.push_back(r);
  endfunction

  task automatic offer_round(input in_word_t w, input logic pin, input out_word_t pw);
    if (!no_gaps && $urandom_range(0, 99) < 22) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_data     <= w;
    pinned_ok   <= pin;
    pinned_word <= pw;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // leaves cfg_valid high so back-to-back writes never lower and raise it in one step
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TIME_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (led_status_due.size() != 0) @(posedge clk);
  endtask

  initial begin
    in_word_t          w;
    logic [KEYS-1:0]   held;
    logic [TIME_W-1:0] clock_now;
    logic [TIME_W-1:0] wr_high, wr_low, wr_pause;
    int                step_max;
    bit                poke_spare;

    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    in_data     <= '0;
    cfg_valid   <= 1'b0;
    cfg_index   <= CFG_HIGH_TIME;
    cfg_data    <= '0;
    pinned_ok   <= 1'b0;
    pinned_word <= '0;
    t_high       = HIGH_TIME_RST;
    t_low        = LOW_TIME_RST;
    t_pause      = PAUSE_TIME_RST;
    pressed_last = '0;
    fifo_head    = 0;
    fifo_fill    = 0;
    seq_phase    = PH_READY;
    blinks_left  = '0;
    phase_t0     = '0;
    led_lit      = 1'b0;

    // walk through one blink, then fill the fifo to overflow with the lit phase held
    add_row(4'hF, 32'h0000_0000, 1'b1, 1'b0, 0, 1'b0);
    add_row(4'h0, 32'hFFFF_FFFF, 1'b1, 1'b0, 0, 1'b0);
    add_row(4'hF, 32'h0000_0000, 1'b1, 1'b1, 3, 1'b0);
    add_row(4'hF, 32'd1279,      1'b1, 1'b1, 3, 1'b0);
    add_row(4'hF, 32'd1280,      1'b1, 1'b0, 3, 1'b0);
    add_row(4'hF, 32'd3200,      1'b1, 1'b0, 3, 1'b0);
    add_row(4'hF, 32'd35200,     1'b1, 1'b0, 3, 1'b0);
    add_row(4'hF, 32'd35201,     1'b1, 1'b1, 2, 1'b0);
    add_row(4'h0, 32'd35201,     1'b1, 1'b1, 2, 1'b0);
    add_row(4'hF, 32'd35201,     1'b1, 1'b1, 6, 1'b0);
    add_row(4'h0, 32'd35201,     1'b0, 1'b0, 0, 1'b0);
    add_row(4'hF, 32'd35201,     1'b0, 1'b0, 0, 1'b0);
    add_row(4'h0, 32'd35201,     1'b0, 1'b0, 0, 1'b0);
    add_row(4'hF, 32'd35201,     1'b0, 1'b0, 0, 1'b0);
    add_row(4'h0, 32'd35201,     1'b0, 1'b0, 0, 1'b0);
    add_row(4'hF, 32'd35201,     1'b1, 1'b1, 16, 1'b1);
    add_row(4'h7, 32'd35201,     1'b0, 1'b0, 0, 1'b0);
    add_row(4'hF, 32'd35201,     1'b1, 1'b1, 16, 1'b1);
    add_row(4'hF, 32'hFFFF_FFFF, 1'b0, 1'b0, 0, 1'b0);
    add_row(4'hF, 32'h0000_0000, 1'b0, 1'b0, 0, 1'b0);
    add_row(4'hF, 32'd1919,      1'b0, 1'b0, 0, 1'b0);
    add_row(4'hA, 32'd1920,      1'b0, 1'b0, 0, 1'b0);
    add_row(4'h5, 32'd1921,      1'b0, 1'b0, 0, 1'b0);

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (drill[i]) offer_round(drill[i].stim, drill[i].pinned, drill[i].want);

    held      = ~drill[drill.size()-1].stim.key_pins;
    clock_now = drill[drill.size()-1].stim.now;

    for (int p = 0; p < PHASES; p++) begin
      settle();
      poke_spare = 1'b0;
      no_gaps    = 1'b0;
      case (p)
        0: begin
          wr_high = HIGH_TIME_RST; wr_low = LOW_TIME_RST; wr_pause = PAUSE_TIME_RST;
          step_max = 600;
        end
        1: begin
          wr_high = '0; wr_low = '0; wr_pause = '0;
          step_max = 3;
        end
        2: begin
          wr_high = 32'd1; wr_low = 32'd1; wr_pause = 32'd1;
          step_max = 3;
        end
        3: begin
          // nothing finishes, so the fifo fills and releases get dropped
          wr_high = '1; wr_low = '1; wr_pause = '1;
          step_max = 50;
        end
        4: begin
          wr_high  = $urandom_range(1, 20);
          wr_low   = $urandom_range(1, 20);
          wr_pause = $urandom_range(1, 20);
          step_max = 8;
          poke_spare = 1'b1;
        end
        5: begin
          wr_high  = $urandom_range(0, 40);
          wr_low   = $urandom_range(0, 40);
          wr_pause = $urandom_range(0, 40);
          step_max = 16;
          no_gaps  = 1'b1;
        end
        6: begin
          wr_high  = $urandom_range(1, 30);
          wr_low   = 32'd1;
          wr_pause = '1;
          step_max = 8;
        end
        default: begin
          wr_high  = $urandom();
          wr_low   = $urandom_range(0, 30);
          wr_pause = '0;
          step_max = 12;
        end
      endcase
      write_reg(CFG_HIGH_TIME, wr_high);
      write_reg(CFG_LOW_TIME, wr_low);
      write_reg(CFG_PAUSE_TIME, wr_pause);
      if (poke_spare) write_reg(CFG_SPARE, $urandom());
      cfg_valid <= 1'b0;

      for (int i = 0; i < PHASE_WORDS; i++) begin
        if (p == 0 && i == 60) hold_off_req = 1'b1;
        if ($urandom_range(0, 39) == 0) begin
          clock_now = $urandom();
        end else if ($urandom_range(0, 199) == 0) begin
          clock_now = 32'hFFFF_FF00 | $urandom_range(0, 255);
        end else begin
          clock_now = clock_now + $urandom_range(0, step_max);
        end
        if ($urandom_range(0, 19) == 0) begin
          held = KEYS'($urandom_range(0, 15));
        end else if ($urandom_range(0, 29) == 0) begin
          held = (held == '0) ? '1 : '0;
        end else begin
          for (int k = 0; k < KEYS; k++)
            if ($urandom_range(0, 5) == 0) held[k] = ~held[k];
        end
        w.key_pins = ~held;
        w.now      = clock_now;
        offer_round(w, 1'b0, '0);
      end
    end

    settle();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && led_status_due.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
